// File: hdl/ght_pkg.sv
package ght_pkg;

   // Defaults for the top-level parameters.
   localparam int unsigned DEF_SLOTS       = 128;
   localparam int unsigned DEF_HANDLE_BASE = 5;

   localparam logic [15:0] GEN_WRAP_VALUE = 16'hffff;
   localparam logic [15:0] GEN_FIRST      = 16'h0001;
   localparam logic [15:0] REFCOUNT_MAX   = 16'hffff;

   typedef enum logic [1:0] {
      OP_ALLOCATE = 2'd0,
      OP_LOCK     = 2'd1,
      OP_UNLOCK   = 2'd2,
      OP_LOOKUP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_FULL     = 2'd2,
      ST_SHUTDOWN = 2'd3
   } status_type;

   typedef struct packed {
      op_type      operation;
      logic [31:0] handle;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] handle_out;
      logic [6:0]  slot_index;
      logic        slot_released;
      logic        system_handle;
   } rsp_type;

endpackage

// File: hdl/ght_bypass_ram.sv
module ght_bypass_ram import ght_pkg::*; #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = DEF_SLOTS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A write to the address being read in the same cycle is passed through.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/generational_handle_table.sv
// Generational handle table. Each request carries an operation (allocate, lock, unlock or
// look up) and a handle whose upper half is slot plus HANDLE_BASE and whose lower half is
// the generation; each request yields exactly one response item. The block takes one item
// every cycle unless stalled. The execute stage registers the item together with the slot
// entry read from the slot memory; it then resolves the operation, updates the slot, free
// list and generation state, and loads the result register. A response stalled at the
// output holds the execute stage, and while that stage holds an item that cannot execute
// the request side is stalled in the same cycle. Slots that were never allocated
// read as zero because their index lies at or above the never-used pointer, so no clearing
// pass is needed after reset. Allocation fails with shut-down status until platform_active
// is written to one.
module generational_handle_table import ght_pkg::*; #(
   parameter int unsigned SLOTS       = DEF_SLOTS,
   parameter int unsigned HANDLE_BASE = DEF_HANDLE_BASE
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   localparam int unsigned SLOT_W    = $clog2(SLOTS);
   localparam logic [16:0] BASE_EXT  = 17'(HANDLE_BASE);
   localparam logic [16:0] SLOTS_EXT = 17'(SLOTS);

   // Configuration.
   logic platform_active_ff;

   // Execute stage registers.
   logic        s1_valid_ff, s1_valid_in;
   op_type      s1_op_ff;
   logic [31:0] s1_handle_ff;

   // Table state.
   logic [SLOT_W-1:0] free_head_ff, free_head_in;
   logic              free_valid_ff, free_valid_in;
   logic [SLOT_W:0]   next_unused_ff, next_unused_in;
   logic [15:0]       generation_ff, generation_in;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type result;

   logic out_free, exec, req_accept;

   // Memory ports.
   logic              slot_wr_en;
   logic [SLOT_W-1:0] slot_wr_addr;
   logic [31:0]       slot_wr_data;
   logic [SLOT_W-1:0] slot_rd_addr;
   logic [31:0]       slot_rd;
   logic              link_wr_en;
   logic [SLOT_W:0]   link_wr_data;
   logic [SLOT_W:0]   link_rd;

   // Decode of the executing item.
   logic [15:0] hi;
   logic [16:0] idx17;
   logic [16:0] req_idx17;
   logic        in_range, live, handle_ok;
   logic [15:0] cnt, gen, cnt_dec, gen_inc, gen_new;
   logic        have_unused;
   logic [SLOT_W-1:0] alloc_slot;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign exec       = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   // The slot memory is read as the item enters, addressed by its handle.
   assign req_idx17    = {1'b0, req_payload.handle[31:16]} - BASE_EXT;
   assign slot_rd_addr = req_idx17[SLOT_W-1:0];

   ght_bypass_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (req_accept),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd)
   );

   // The link memory always holds the entry after the next head, so a pop has its
   // successor ready. Each entry stores the link and whether that link is valid.
   ght_bypass_ram #(.WIDTH(SLOT_W + 1), .DEPTH(SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (idx17[SLOT_W-1:0]),
      .wr_data (link_wr_data),
      .rd_en   (1'b1),
      .rd_addr (free_head_in),
      .rd_data (link_rd)
   );

   always_comb begin
      hi        = s1_handle_ff[31:16];
      idx17     = {1'b0, hi} - BASE_EXT;
      in_range  = ({1'b0, hi} >= BASE_EXT) && (idx17 < SLOTS_EXT);
      // Entries at or past the never-used pointer have never been written and read as zero.
      live      = in_range && (idx17 < 17'(next_unused_ff));
      cnt       = live ? slot_rd[15:0]  : 16'd0;
      gen       = live ? slot_rd[31:16] : 16'd0;
      handle_ok = in_range && (cnt != 16'd0) && (s1_handle_ff[15:0] == gen);
      cnt_dec   = cnt - 16'd1;

      gen_inc = generation_ff + 16'd1;
      gen_new = ((gen_inc == GEN_WRAP_VALUE) || (gen_inc == 16'd0)) ? GEN_FIRST : gen_inc;

      have_unused = next_unused_ff < (SLOT_W + 1)'(SLOTS);
      alloc_slot  = free_valid_ff ? free_head_ff : next_unused_ff[SLOT_W-1:0];
   end

   always_comb begin
      result         = '0;
      result.status  = ST_OK;
      slot_wr_en     = 1'b0;
      slot_wr_addr   = idx17[SLOT_W-1:0];
      slot_wr_data   = {gen, cnt};
      link_wr_en     = 1'b0;
      link_wr_data   = {free_valid_ff, free_head_ff};
      free_head_in   = free_head_ff;
      free_valid_in  = free_valid_ff;
      next_unused_in = next_unused_ff;
      generation_in  = generation_ff;

      case (s1_op_ff)
         OP_ALLOCATE: begin
            if (!platform_active_ff) begin
               result.status = ST_SHUTDOWN;
            end else if (free_valid_ff || have_unused) begin
               slot_wr_en        = exec;
               slot_wr_addr      = alloc_slot;
               slot_wr_data      = {gen_new, 16'd1};
               generation_in     = gen_new;
               result.handle_out = {16'(17'(alloc_slot) + BASE_EXT), gen_new};
               result.slot_index = 7'(16'(alloc_slot));
               if (free_valid_ff) begin
                  // Pop the free list.
                  free_head_in  = link_rd[SLOT_W-1:0];
                  free_valid_in = link_rd[SLOT_W];
               end else begin
                  next_unused_in = next_unused_ff + 1'b1;
               end
            end else begin
               result.status = ST_FULL;
            end
         end
         default: begin
            if (((s1_op_ff == OP_LOCK) || (s1_op_ff == OP_UNLOCK)) && (hi == 16'd0)) begin
               // A system handle passes unchecked and touches nothing.
               result.system_handle = 1'b1;
            end else if (!handle_ok) begin
               result.status = ST_INVALID;
            end else begin
               result.slot_index = 7'(idx17);
               if (s1_op_ff == OP_LOCK) begin
                  slot_wr_en   = exec;
                  slot_wr_data = {gen, (cnt == REFCOUNT_MAX) ? cnt : cnt + 16'd1};
               end else if (s1_op_ff == OP_UNLOCK) begin
                  slot_wr_en   = exec;
                  slot_wr_data = {gen, cnt_dec};
                  if (cnt_dec == 16'd0) begin
                     // Last reference gone: push the slot on the free list.
                     link_wr_en           = exec;
                     free_head_in         = idx17[SLOT_W-1:0];
                     free_valid_in        = 1'b1;
                     result.slot_released = 1'b1;
                  end
               end
            end
         end
      endcase

      // State only moves when the item actually executes.
      if (!exec) begin
         free_head_in   = free_head_ff;
         free_valid_in  = free_valid_ff;
         next_unused_in = next_unused_ff;
         generation_in  = generation_ff;
      end
   end

   assign s1_valid_in = req_accept ? 1'b1 : (exec ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         platform_active_ff <= 1'b0;
         s1_valid_ff        <= 1'b0;
         free_valid_ff      <= 1'b0;
         next_unused_ff     <= '0;
         generation_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            platform_active_ff <= csr_write_data;
         end
         s1_valid_ff    <= s1_valid_in;
         free_valid_ff  <= free_valid_in;
         next_unused_ff <= next_unused_in;
         generation_ff  <= generation_in;
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      free_head_ff <= free_head_in;
      if (req_accept) begin
         s1_op_ff     <= req_payload.operation;
         s1_handle_ff <= req_payload.handle;
      end
      if (exec) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// File: verif/generational_handle_table_tb.sv
module generational_handle_table_tb;
   import ght_pkg::*;

   localparam int unsigned SLOTS = DEF_SLOTS;
   localparam int unsigned BASE  = DEF_HANDLE_BASE;
   // Time that wait_until_drained idles after the last owed response, so
   // that anything still in flight has surely reached the output.
   localparam int unsigned SETTLE_CYCLES = 6;

   logic    clock            = 1'b0;
   logic    reset            = 1'b1;
   logic    req_valid        = 1'b0;
   logic    req_stall;
   req_type req_payload      = '0;
   logic    rsp_valid;
   logic    rsp_stall        = 1'b0;
   rsp_type rsp_payload;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data   = 1'b0;

   always #1 clock = ~clock;

   generational_handle_table #(
      .SLOTS       (SLOTS),
      .HANDLE_BASE (BASE)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the table. It is updated in acceptance order, so the
   // expected response of every item is known the moment the item is taken.
   logic [15:0] slot_count [SLOTS];
   logic [15:0] slot_tag [SLOTS];
   int unsigned next_free [SLOTS];
   bit          next_free_ok [SLOTS];
   int unsigned free_top;
   bit          free_top_ok;
   int unsigned fresh_slot;
   logic [15:0] current_tag;
   bit          platform_on;

   // Responses that the block still owes us, oldest first.
   rsp_type pending_results [$];
   rsp_type last_result;
   int      mismatch_count = 0;

   // When clear, neither side inserts gaps, which keeps the long runs short.
   bit idle_on = 1'b1;
   int stall_left = 0;

   // Gap lengths: mostly none, often short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] slot_handle(int unsigned slot);
      return {16'(slot + BASE), slot_tag[slot]};
   endfunction

   // Works out the response to one request and applies its side effects to
   // the shadow table: free list pops and pushes, counts and generations.
   function automatic rsp_type table_response(op_type op, logic [31:0] h);
      rsp_type     r;
      int unsigned upper;
      int unsigned slot;
      logic [15:0] tag;
      r = '0;
      upper = h[31:16];
      if (op == OP_ALLOCATE) begin
         if (!platform_on) begin
            r.status = ST_SHUTDOWN;
         end else if (!(free_top_ok && free_top < SLOTS) && fresh_slot >= SLOTS) begin
            // Nothing on the free list and every slot handed out once; the
            // generation stays where it is.
            r.status = ST_FULL;
         end else begin
            if (free_top_ok && free_top < SLOTS) begin
               slot = free_top;
               free_top_ok = next_free_ok[slot];
               free_top = next_free[slot];
            end else begin
               slot = fresh_slot;
               fresh_slot++;
            end
            // The generation skips both zero and the all-ones value.
            tag = current_tag + 16'd1;
            if (tag == GEN_WRAP_VALUE || tag == 16'd0) begin
               tag = GEN_FIRST;
            end
            current_tag = tag;
            slot_count[slot] = 16'd1;
            slot_tag[slot] = tag;
            r.handle_out = {16'(slot + BASE), tag};
            r.slot_index = 7'(slot);
         end
      end else if (op != OP_LOOKUP && upper == 0) begin
         // Lock and unlock pass a handle with an empty upper half untouched.
         r.system_handle = 1'b1;
      end else if (upper < BASE || upper - BASE >= SLOTS) begin
         r.status = ST_INVALID;
      end else if (slot_count[upper - BASE] == 16'd0 ||
                   h[15:0] != slot_tag[upper - BASE]) begin
         r.status = ST_INVALID;
      end else begin
         slot = upper - BASE;
         r.slot_index = 7'(slot);
         if (op == OP_LOCK) begin
            // The count sticks at its maximum rather than wrapping.
            if (slot_count[slot] != REFCOUNT_MAX) begin
               slot_count[slot] = slot_count[slot] + 16'd1;
            end
         end else if (op == OP_UNLOCK) begin
            slot_count[slot] = slot_count[slot] - 16'd1;
            if (slot_count[slot] == 16'd0) begin
               next_free[slot] = free_top;
               next_free_ok[slot] = free_top_ok;
               free_top = slot;
               free_top_ok = 1'b1;
               r.slot_released = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Presents one item after an optional gap, holds it until the block takes
   // it, and then records what the block has to answer.
   task automatic send_item(input op_type op, input logic [31:0] h);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{operation: op, handle: h};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      last_result = table_response(op, h);
      pending_results.push_back(last_result);
   endtask

   // Drops valid and waits until every owed response has come out, then
   // idles for SETTLE_CYCLES so that the pipeline is empty for sure.
   task automatic wait_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // The register is only written with the block idle.
   task automatic set_platform_active(input bit value);
      wait_until_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      platform_on = value;
   endtask

   function automatic bit find_live_handle(output logic [31:0] h);
      int unsigned start;
      int unsigned slot;
      start = $urandom_range(0, SLOTS - 1);
      for (int unsigned k = 0; k < SLOTS; k++) begin
         slot = (start + k) % SLOTS;
         if (slot_count[slot] != 16'd0) begin
            h = slot_handle(slot);
            return 1'b1;
         end
      end
      h = '0;
      return 1'b0;
   endfunction

   // One random item. Apart from allocations, most items use handles that are
   // alive right now, so that counts rise and fall and slots cycle through
   // the free list; the rest are stale or corrupted handles, system handles,
   // out-of-range slots and plain noise.
   task automatic random_item(input int alloc_pct, input int unlock_pct);
      logic [31:0] h;
      int          r;
      int unsigned upper;
      int unsigned slot;
      op_type      op;
      r = $urandom_range(0, 99);
      op = op_type'($urandom_range(1, 3));
      if (r < alloc_pct) begin
         send_item(OP_ALLOCATE, $urandom());
      end else if (r < 82) begin
         if (!find_live_handle(h)) begin
            send_item(OP_ALLOCATE, $urandom());
         end else if ($urandom_range(0, 99) < unlock_pct) begin
            send_item(OP_UNLOCK, h);
         end else begin
            send_item($urandom_range(0, 1) ? OP_LOCK : OP_LOOKUP, h);
         end
      end else if (r < 89) begin
         // A handle to any slot, freed or not, sometimes with one bit of its
         // generation flipped.
         slot = $urandom_range(0, SLOTS - 1);
         h = slot_handle(slot);
         if ($urandom_range(0, 1)) begin
            h[$urandom_range(0, 15)] ^= 1'b1;
         end
         send_item(op_type'($urandom_range(0, 3)), h);
      end else if (r < 93) begin
         send_item(op, {16'h0000, 16'($urandom())});
      end else if (r < 96) begin
         upper = $urandom_range(0, 1) ? $urandom_range(1, BASE - 1)
                                      : $urandom_range(BASE + SLOTS, 16'hffff);
         send_item(op, {16'(upper), 16'($urandom())});
      end else begin
         send_item(op_type'($urandom_range(0, 3)), $urandom());
      end
   endtask

   task automatic run_phase(input int count, input int alloc_pct, input int unlock_pct);
      repeat (count) random_item(alloc_pct, unlock_pct);
   endtask

   // Out of reset the platform is down: allocation must fail, while handle
   // checks and system handles behave as usual.
   task automatic test_shutdown_and_bounds();
      send_item(OP_ALLOCATE, 32'hffff_ffff);
      send_item(OP_LOCK, 32'hffff_ffff);
      send_item(OP_LOOKUP, 32'h0000_0000);
      send_item(OP_LOCK, 32'h0000_ffff);
      send_item(OP_UNLOCK, 32'h0000_0000);
      send_item(OP_LOOKUP, {16'(BASE - 1), 16'h0001});
      send_item(OP_UNLOCK, {16'(BASE + SLOTS), 16'h0000});
      set_platform_active(1'b0);
      send_item(OP_ALLOCATE, 32'h0000_0000);
      set_platform_active(1'b1);
   endtask

   // Allocation from fresh slots, lock and unlock around release, and reuse
   // of freed slots in last-in, first-out order.
   task automatic test_lock_unlock_cycle();
      logic [31:0] first;
      logic [31:0] second;
      logic [31:0] third;
      send_item(OP_ALLOCATE, 32'h0);
      first = last_result.handle_out;
      send_item(OP_ALLOCATE, 32'h0);
      second = last_result.handle_out;
      send_item(OP_ALLOCATE, 32'h0);
      third = last_result.handle_out;
      send_item(OP_LOOKUP, first);
      send_item(OP_LOCK, first);
      send_item(OP_LOOKUP, first ^ 32'h0000_0001);
      // A slot past the last one handed out has count zero and generation
      // zero, so a matching generation alone must not make it valid.
      send_item(OP_LOOKUP, {16'(BASE + 3), 16'h0000});
      send_item(OP_UNLOCK, second);
      send_item(OP_LOOKUP, second);
      send_item(OP_UNLOCK, second);
      send_item(OP_UNLOCK, first);
      send_item(OP_UNLOCK, first);
      send_item(OP_ALLOCATE, 32'h0);
      send_item(OP_ALLOCATE, 32'h0);
      send_item(OP_LOCK, {16'(BASE + SLOTS - 1), 16'h0000});
      // Look up gets no pass for an empty upper half.
      send_item(OP_LOOKUP, 32'h0000_0001);
      send_item(OP_UNLOCK, third);
      send_item(OP_LOOKUP, third);
   endtask

   // Hand out every slot, ask for more, then free the whole table in a
   // scattered order so the free list gets long and mixed.
   task automatic test_table_full();
      int unsigned offset;
      int unsigned slot;
      send_item(OP_ALLOCATE, 32'h0);
      while (last_result.status == ST_OK) send_item(OP_ALLOCATE, 32'h0);
      send_item(OP_ALLOCATE, 32'hffff_ffff);
      send_item(OP_LOOKUP, slot_handle(SLOTS - 1));
      offset = $urandom_range(0, SLOTS - 1);
      for (int unsigned k = 0; k < SLOTS; k++) begin
         slot = (k * 37 + offset) % SLOTS;
         while (slot_count[slot] != 16'd0) send_item(OP_UNLOCK, slot_handle(slot));
      end
      send_item(OP_ALLOCATE, 32'h0);
   endtask

   // Random traffic in phases: balanced, without any idling, with the
   // platform down, filling the table, draining it again and balanced once more.
   task automatic test_random_traffic();
      run_phase(150, 20, 50);
      idle_on = 1'b0;
      run_phase(120, 20, 50);
      idle_on = 1'b1;
      set_platform_active(1'b0);
      run_phase(40, 20, 50);
      set_platform_active(1'b1);
      run_phase(200, 45, 20);
      run_phase(200, 8, 75);
      idle_on = $urandom_range(0, 3) != 0;
      run_phase(150, 20, 50);
      idle_on = 1'b1;
   endtask

   // Receiver back pressure: each stall has a random length from pick_gap.
   always @(negedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= stall_left > 0;
         if (stall_left > 0) stall_left--;
      end
   end

   // Every response taken from the block is matched against the oldest one
   // still owed; only the first few disagreements are printed in detail.
   always @(posedge clock) begin
      rsp_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected response: handle=%h", rsp_payload.handle_out);
            end
         end else begin
            owed = pending_results.pop_front();
            if (rsp_payload.status !== owed.status ||
                rsp_payload.handle_out !== owed.handle_out ||
                rsp_payload.slot_index !== owed.slot_index ||
                rsp_payload.slot_released !== owed.slot_released ||
                rsp_payload.system_handle !== owed.system_handle) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch expected: status=%0d handle=%h slot=%0d rel=%b sys=%b",
                           owed.status, owed.handle_out, owed.slot_index,
                           owed.slot_released, owed.system_handle);
                  $display("mismatch actual:   status=%0d handle=%h slot=%0d rel=%b sys=%b",
                           rsp_payload.status, rsp_payload.handle_out,
                           rsp_payload.slot_index, rsp_payload.slot_released,
                           rsp_payload.system_handle);
               end
            end
         end
      end
   end

   initial begin
      foreach (slot_count[i]) begin
         slot_count[i] = 16'd0;
         slot_tag[i] = 16'd0;
         next_free[i] = 0;
         next_free_ok[i] = 1'b0;
      end
      free_top = 0;
      free_top_ok = 1'b0;
      fresh_slot = 0;
      current_tag = 16'd0;
      platform_on = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_shutdown_and_bounds();
      test_lock_unlock_cycle();
      test_table_full();
      test_random_traffic();

      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Safety net for a hung handshake. Even with the longest gaps and stalls
   // on every item a correct run finishes well within this time limit.
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end

endmodule
